// File: src/gtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gtt_pkg;

  localparam int NUM_TIMERS_DEF  = 16;
  localparam int MS_PER_TICK_DEF = 1;
  localparam int MAX_RESULTS     = 16;

  // Stream payload widths
  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 8;

  // Remainder unit: steps per rounding (reciprocal multiply, back-multiply and
  // subtract, final correction)
  localparam int DIV_STEPS = 3;

  // Action codes; codes above ACT_HANDLE are no-ops with a status result
  localparam logic [3:0] ACT_SET_HANDLER  = 4'd0;
  localparam logic [3:0] ACT_ONESHOT_AFTR = 4'd1;
  localparam logic [3:0] ACT_PERIODIC     = 4'd2;
  localparam logic [3:0] ACT_ONESHOT_AT   = 4'd3;
  localparam logic [3:0] ACT_STOP         = 4'd4;
  localparam logic [3:0] ACT_STOP_GROUP   = 4'd5;
  localparam logic [3:0] ACT_STOP_CLEAR   = 4'd6;
  localparam logic [3:0] ACT_QUERY        = 4'd7;
  localparam logic [3:0] ACT_HANDLE       = 4'd8;

  typedef struct packed {
    logic [30:0] period;
    logic [31:0] expiry;
    logic [7:0]  group;
    logic        handler;
    logic        rpt;
    logic        active;
  } gtt_entry_t;

  localparam int ENTRY_W = $bits(gtt_entry_t);

endpackage

`default_nettype wire

// File: src/gtt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/grouped_timer_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Timer table with one request channel and one result channel.
// A request carries an action in in_tuser and its operands in in_tdata. Actions other
// than handle-group return exactly one status result (out_tuser low, out_tlast high,
// is_active set only for a query of an active timer). Handle-group scans the table
// from entry 0 up, rearms or stops every active, matching, due timer, and returns one
// fired result (out_tuser high) per handled timer with a handler, at most 16; the
// final one carries out_tlast. A scan that fires nothing returns no result.
// The table lives in one single-port-read synchronous RAM; each entry is read,
// modified and written back, one entry at a time, so requests are taken one by one.
// Single-entry action: RAM read, evaluate, write back, then the result moves to the
// output register; the reciprocal-multiply remainder unit runs between evaluate and
// write back when a delay must be rounded and MS_PER_TICK is not a power of two.
// Undefined action: status result straight to the output register. Group actions:
// RAM read, evaluate, write back per entry; remainder unit per rearm that needs it.
// Reset clears the per-entry valid bits at once: all flags and groups read as zero,
// and no clearing pass runs. A stalled receiver holds the scan before the next fired
// result, and holds in_tready low until the last result is in the output register.

module grouped_timer_table_core #(
  parameter int NUM_TIMERS  = gtt_pkg::NUM_TIMERS_DEF,
  parameter int MS_PER_TICK = gtt_pkg::MS_PER_TICK_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // timer_id[3:0], duration_ms[34:4], target_time[66:35], group_mask[74:67],
  // handler_present[75], now_time[107:76], zero fill
  input  wire logic [gtt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action[3:0]
  input  wire logic [gtt_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // fired_id[3:0], is_active[4], zero fill
  output logic      [gtt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // fired_valid
  output logic                                   out_tuser,
  output logic                                   out_tlast
);

  import gtt_pkg::*;

  localparam int  IW        = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int  RW        = $clog2(MS_PER_TICK) + 1;
  localparam int  FCW       = $clog2(MAX_RESULTS + 1);
  localparam int  DCW       = $clog2(DIV_STEPS);
  localparam bit  TICK_POW2 = (MS_PER_TICK & (MS_PER_TICK - 1)) == 0;
  // floor(2^32 / MS_PER_TICK); only used when the tick is not a power of two
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MS_PER_TICK));

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_EV    = 6'b000100,
    S_DIV   = 6'b001000,
    S_WR    = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Request fields
  logic [3:0]  act_r,  act_nxt;
  logic [30:0] dur_r,  dur_nxt;
  logic [31:0] tgt_r,  tgt_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic        hp_r,   hp_nxt;
  logic [31:0] now_r,  now_nxt;
  logic        scan_r, scan_nxt;

  logic [IW-1:0]         idx_r, idx_nxt;
  logic [NUM_TIMERS-1:0] vld_r, vld_nxt;
  logic                  ent_vld_r, ent_vld_nxt;
  logic [FCW-1:0]        fcnt_r, fcnt_nxt;

  // Remainder unit
  logic [31:0]    ms_r, ms_nxt;
  logic [31:0]    quo_r, quo_nxt;
  logic [31:0]    est_r, est_nxt;
  logic [RW-1:0]  rem_r, rem_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [63:0]    prod;
  logic [31:0]    est_step;
  logic [RW-1:0]  rem_step;

  // Result waiting for its last flag
  logic       pend_v_r, pend_v_nxt;
  logic       pend_fv_r, pend_fv_nxt;
  logic [3:0] pend_id_r, pend_id_nxt;
  logic       pend_act_r, pend_act_nxt;

  // Output register
  logic       out_v_r, out_v_nxt;
  logic       out_fv_r, out_fv_nxt;
  logic [3:0] out_id_r, out_id_nxt;
  logic       out_act_r, out_act_nxt;
  logic       out_last_r, out_last_nxt;

  // RAM
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  logic               ram_re;
  gtt_entry_t         ent;
  gtt_entry_t         new_ent;

  // Input decode
  logic [3:0]  in_action;
  logic [3:0]  in_timer_id;
  logic [30:0] in_duration_ms;
  logic [31:0] in_target_time;
  logic [7:0]  in_group_mask;
  logic        in_handler_present;
  logic [31:0] in_now_time;
  logic        in_ok;
  logic        in_scan;

  logic [31:0]   diff;
  logic          match;
  logic          hit;
  logic          need_rnd;
  logic [RW-1:0] rem_use;
  logic [31:0]   rnd;
  logic          wr_en;
  logic          fire;
  logic          slot_free;
  logic          stall;

  assign in_action          = in_tuser[3:0];
  assign in_timer_id        = in_tdata[3:0];
  assign in_duration_ms     = in_tdata[34:4];
  assign in_target_time     = in_tdata[66:35];
  assign in_group_mask      = in_tdata[74:67];
  assign in_handler_present = in_tdata[75];
  assign in_now_time        = in_tdata[107:76];
  assign in_ok   = 32'(in_timer_id) < 32'(NUM_TIMERS);
  assign in_scan = (in_action == ACT_STOP_GROUP) || (in_action == ACT_STOP_CLEAR) ||
                   (in_action == ACT_HANDLE);

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_fv_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_act_r, out_id_r};

  assign slot_free = !out_v_r || out_tready;

  // Entry under work; an entry never written reads as all zero
  assign ent      = ent_vld_r ? gtt_entry_t'(ram_rdata) : gtt_entry_t'('0);
  assign diff     = now_r - ent.expiry;
  assign match    = |(ent.group & mask_r);
  assign hit      = (act_r == ACT_HANDLE) && ent.active && !diff[31] && match;
  assign need_rnd = (act_r == ACT_ONESHOT_AFTR) || (act_r == ACT_PERIODIC) ||
                    (hit && ent.rpt);

  assign rem_use = TICK_POW2 ? (ms_r[RW-1:0] & RW'(MS_PER_TICK - 1)) : rem_r;
  assign rnd     = ms_r + ((rem_use != '0) ? (32'(MS_PER_TICK) - 32'(rem_use)) : 32'd0);
  assign fire    = hit && ent.handler && (fcnt_r < FCW'(MAX_RESULTS));
  assign stall   = fire && pend_v_r && !slot_free;

  // Remainder pipeline: the quotient estimate is low by at most one, so the
  // estimated remainder lies below twice the tick and one subtract corrects it
  assign prod     = {32'd0, ms_r} * {32'd0, RECIP};
  assign est_step = ms_r - 32'(quo_r * 32'(MS_PER_TICK));
  assign rem_step = (est_r >= 32'(MS_PER_TICK)) ? RW'(est_r - 32'(MS_PER_TICK)) :
                                                  RW'(est_r);

  // Modified entry
  always_comb begin
    new_ent = ent;
    wr_en   = 1'b0;
    case (act_r)
      ACT_SET_HANDLER: begin
        new_ent.handler = hp_r;
        new_ent.group   = mask_r;
        wr_en           = 1'b1;
      end
      ACT_ONESHOT_AFTR: begin
        new_ent.expiry = now_r + rnd;
        new_ent.rpt    = 1'b0;
        new_ent.active = 1'b1;
        wr_en          = 1'b1;
      end
      ACT_PERIODIC: begin
        new_ent.expiry = now_r + rnd;
        new_ent.period = dur_r;
        new_ent.rpt    = 1'b1;
        new_ent.active = 1'b1;
        wr_en          = 1'b1;
      end
      ACT_ONESHOT_AT: begin
        new_ent.expiry = tgt_r;
        new_ent.rpt    = 1'b0;
        new_ent.active = 1'b1;
        wr_en          = 1'b1;
      end
      ACT_STOP: begin
        new_ent.rpt    = 1'b0;
        new_ent.active = 1'b0;
        wr_en          = 1'b1;
      end
      ACT_STOP_GROUP, ACT_STOP_CLEAR: begin
        new_ent.rpt    = 1'b0;
        new_ent.active = 1'b0;
        if (act_r == ACT_STOP_CLEAR) begin
          new_ent.handler = 1'b0;
        end
        wr_en = match;
      end
      ACT_HANDLE: begin
        if (ent.rpt) begin
          new_ent.expiry = now_r + rnd;
        end else begin
          new_ent.active = 1'b0;
        end
        wr_en = hit;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign ram_re = state_r == S_RD;
  assign ram_we = (state_r == S_WR) && !stall && wr_en;

  // Read and write never overlap on one entry: the write back of an entry lands
  // before the next read is issued.
  gtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx_r),
    .wr_data (new_ent),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    dur_nxt      = dur_r;
    tgt_nxt      = tgt_r;
    mask_nxt     = mask_r;
    hp_nxt       = hp_r;
    now_nxt      = now_r;
    scan_nxt     = scan_r;
    idx_nxt      = idx_r;
    vld_nxt      = vld_r;
    ent_vld_nxt  = ent_vld_r;
    fcnt_nxt     = fcnt_r;
    ms_nxt       = ms_r;
    quo_nxt      = quo_r;
    est_nxt      = est_r;
    rem_nxt      = rem_r;
    dcnt_nxt     = dcnt_r;
    pend_v_nxt   = pend_v_r;
    pend_fv_nxt  = pend_fv_r;
    pend_id_nxt  = pend_id_r;
    pend_act_nxt = pend_act_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_fv_nxt   = out_fv_r;
    out_id_nxt   = out_id_r;
    out_act_nxt  = out_act_r;
    out_last_nxt = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt  = in_action;
          dur_nxt  = in_duration_ms;
          tgt_nxt  = in_target_time;
          mask_nxt = in_group_mask;
          hp_nxt   = in_handler_present;
          now_nxt  = in_now_time;
          scan_nxt = in_scan;
          fcnt_nxt = '0;
          idx_nxt  = in_scan ? '0 : IW'(in_timer_id);
          if (in_scan || (in_ok && (in_action <= ACT_QUERY))) begin
            // Group stops report one status result once the scan is over
            pend_v_nxt   = in_action != ACT_HANDLE;
            pend_fv_nxt  = 1'b0;
            pend_id_nxt  = 4'd0;
            pend_act_nxt = 1'b0;
            state_nxt    = S_RD;
          end else begin
            // Nothing to touch: report status only
            pend_v_nxt   = 1'b1;
            pend_fv_nxt  = 1'b0;
            pend_id_nxt  = 4'd0;
            pend_act_nxt = 1'b0;
            state_nxt    = S_FLUSH;
          end
        end
      end
      S_RD: begin
        ent_vld_nxt = vld_r[idx_r];
        state_nxt   = S_EV;
      end
      S_EV: begin
        ms_nxt   = (act_r == ACT_HANDLE) ? {1'b0, ent.period} : {1'b0, dur_r};
        rem_nxt  = '0;
        dcnt_nxt = '0;
        state_nxt = (need_rnd && !TICK_POW2) ? S_DIV : S_WR;
      end
      S_DIV: begin
        quo_nxt  = prod[63:32];
        est_nxt  = est_step;
        rem_nxt  = rem_step;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(DIV_STEPS - 1)) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        if (!stall) begin
          if (ram_we) begin
            vld_nxt[idx_r] = 1'b1;
          end
          if (!scan_r) begin
            pend_v_nxt   = 1'b1;
            pend_fv_nxt  = 1'b0;
            pend_id_nxt  = 4'd0;
            pend_act_nxt = (act_r == ACT_QUERY) && ent.active;
            state_nxt    = S_FLUSH;
          end else begin
            if (fire) begin
              // Release the previous fired result; it is not the last one
              if (pend_v_r) begin
                out_v_nxt    = 1'b1;
                out_fv_nxt   = pend_fv_r;
                out_id_nxt   = pend_id_r;
                out_act_nxt  = pend_act_r;
                out_last_nxt = 1'b0;
              end
              pend_v_nxt   = 1'b1;
              pend_fv_nxt  = 1'b1;
              pend_id_nxt  = 4'(idx_r);
              pend_act_nxt = 1'b0;
              fcnt_nxt     = fcnt_r + 1'b1;
            end
            if (idx_r == IW'(NUM_TIMERS - 1)) begin
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_v_nxt    = 1'b1;
          out_fv_nxt   = pend_fv_r;
          out_id_nxt   = pend_id_r;
          out_act_nxt  = pend_act_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vld_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vld_r    <= vld_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    dur_r      <= dur_nxt;
    tgt_r      <= tgt_nxt;
    mask_r     <= mask_nxt;
    hp_r       <= hp_nxt;
    now_r      <= now_nxt;
    scan_r     <= scan_nxt;
    idx_r      <= idx_nxt;
    ent_vld_r  <= ent_vld_nxt;
    fcnt_r     <= fcnt_nxt;
    ms_r       <= ms_nxt;
    quo_r      <= quo_nxt;
    est_r      <= est_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    pend_fv_r  <= pend_fv_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_act_r <= pend_act_nxt;
    out_fv_r   <= out_fv_nxt;
    out_id_r   <= out_id_nxt;
    out_act_r  <= out_act_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// File: src/gtt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gtt_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [gtt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              out_tuser,
  input wire logic                              out_tlast
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // One request at a time: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // A status result is always the only, and so the last, result of its request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[3:0] == 4'd0))
    else $error("malformed status result");

  // Fired results never report an active flag
  a_fired_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[4])
    else $error("fired result carries active flag");

endmodule

bind grouped_timer_table_core gtt_checker u_gtt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import gtt_pkg::*;

  localparam int          TIMERS       = NUM_TIMERS_DEF;
  localparam logic [31:0] TICK_MS      = MS_PER_TICK_DEF;
  localparam logic [3:0]  ACT_TOP_CODE = 4'hF;
  localparam int          RANDOM_ITEMS = 380;
  localparam int          IDLE_PCT     = 15;
  localparam int          QUIET_LO     = 4000;
  localparam int          QUIET_HI     = 6000;
  localparam int          STALL_AFTER  = 200;
  localparam int          STALL_CYCLES = 400;
  localparam int          TAIL_CYCLES  = 120;
  localparam int          CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  id;
    logic [30:0] dur;
    logic [31:0] target;
    logic [7:0]  mask;
    logic        hp;
    logic [31:0] now;
  } timer_req_t;

  typedef struct packed {
    logic       fired;
    logic [3:0] fid;
    logic       act;
    logic       last;
  } timer_report_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  // Predicted timer table
  logic [31:0] tm_expiry  [TIMERS];
  logic [30:0] tm_period  [TIMERS];
  bit          tm_active  [TIMERS];
  bit          tm_repeat  [TIMERS];
  bit          tm_handler [TIMERS];
  logic [7:0]  tm_group   [TIMERS];

  timer_req_t    req_queue[$];
  timer_report_t report_q[$];
  timer_req_t    cur_req;
  bit            req_taken = 1'b0;
  int            taken_cnt = 0;
  int            errors    = 0;
  int            cyc       = 0;
  int            stall_left = 0;
  bit            stall_done = 1'b0;
  logic          quiet;

  assign quiet = (cyc >= QUIET_LO) && (cyc < QUIET_HI);

  grouped_timer_table_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] tick_round(input logic [31:0] ms);
    logic [31:0] rem;
    rem = ms % TICK_MS;
    if (rem != 0) begin
      ms = ms + (TICK_MS - rem);
    end
    return ms;
  endfunction

  task automatic arm_timer(input int idx, input logic [31:0] ms, input logic [31:0] now);
    tm_expiry[idx] = now + tick_round(ms);
    tm_repeat[idx] = 1'b0;
    tm_active[idx] = 1'b1;
  endtask

  // Update the table for one accepted request and queue the reports it causes
  task automatic apply_request(input timer_req_t r);
    timer_report_t rep;
    logic [31:0]   lag;
    int            fired;
    rep   = '0;
    fired = 0;
    case (r.action)
      ACT_SET_HANDLER: begin
        tm_handler[r.id] = r.hp;
        tm_group[r.id]   = r.mask;
      end
      ACT_ONESHOT_AFTR: arm_timer(r.id, {1'b0, r.dur}, r.now);
      ACT_PERIODIC: begin
        arm_timer(r.id, {1'b0, r.dur}, r.now);
        tm_period[r.id] = r.dur;
        tm_repeat[r.id] = 1'b1;
      end
      ACT_ONESHOT_AT: begin
        tm_expiry[r.id] = r.target;
        tm_repeat[r.id] = 1'b0;
        tm_active[r.id] = 1'b1;
      end
      ACT_STOP: begin
        tm_active[r.id] = 1'b0;
        tm_repeat[r.id] = 1'b0;
      end
      ACT_STOP_GROUP, ACT_STOP_CLEAR: begin
        for (int i = 0; i < TIMERS; i++) begin
          if ((tm_group[i] & r.mask) != 0) begin
            tm_active[i] = 1'b0;
            tm_repeat[i] = 1'b0;
            if (r.action == ACT_STOP_CLEAR) begin
              tm_handler[i] = 1'b0;
            end
          end
        end
      end
      ACT_QUERY: rep.act = tm_active[r.id];
      ACT_HANDLE: begin
        for (int i = 0; i < TIMERS; i++) begin
          lag = r.now - tm_expiry[i];
          if (tm_active[i] && !lag[31] && ((tm_group[i] & r.mask) != 0)) begin
            if (tm_repeat[i]) begin
              arm_timer(i, {1'b0, tm_period[i]}, r.now);
              tm_repeat[i] = 1'b1;
            end else begin
              tm_active[i] = 1'b0;
              tm_repeat[i] = 1'b0;
            end
            if (tm_handler[i] && fired < MAX_RESULTS) begin
              rep.fired = 1'b1;
              rep.fid   = 4'(i);
              report_q.push_back(rep);
              fired++;
            end
          end
        end
        // mark the final fired report
        if (fired > 0) begin
          rep      = report_q.pop_back();
          rep.last = 1'b1;
          report_q.push_back(rep);
        end
      end
      default: ;
    endcase
    if (r.action != ACT_HANDLE) begin
      rep.last = 1'b1;
      report_q.push_back(rep);
    end
  endtask

  task automatic report_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic queue_req(input logic [3:0] a, input logic [3:0] id, input logic [30:0] dur,
                           input logic [31:0] tgt, input logic [7:0] m, input logic hp,
                           input logic [31:0] nw);
    timer_req_t r;
    r.action = a;
    r.id     = id;
    r.dur    = dur;
    r.target = tgt;
    r.mask   = m;
    r.hp     = hp;
    r.now    = nw;
    req_queue.push_back(r);
  endtask

  // Driver: present the next request at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || req_taken) begin
      if (req_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cur_req = req_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cur_req.action;
        in_tdata  <= {4'b0, cur_req.now, cur_req.hp, cur_req.mask, cur_req.target,
                      cur_req.dur, cur_req.id};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off to fill the block
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!stall_done && taken_cnt >= STALL_AFTER) begin
      stall_done = 1'b1;
      stall_left = STALL_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    timer_report_t seen;
    timer_report_t want;
    req_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        apply_request(cur_req);
        req_taken = 1'b1;
        taken_cnt++;
      end
      if (out_tvalid && out_tready) begin
        seen.fired = out_tuser;
        seen.fid   = out_tdata[3:0];
        seen.act   = out_tdata[4];
        seen.last  = out_tlast;
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result expected none got %0h", $time, seen);
          errors++;
        end else begin
          want = report_q.pop_front();
          report_field("fired_valid", 4'(want.fired), 4'(seen.fired));
          report_field("fired_id", want.fid, seen.fid);
          report_field("is_active", 4'(want.act), 4'(seen.act));
          report_field("last", 4'(want.last), 4'(seen.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  initial begin
    while (cyc < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [31:0] clock_ms;
    logic [3:0]  id;
    logic [3:0]  act;
    logic [30:0] dur;
    logic [7:0]  m;
    int          base;
    int          pick;
    int          k;
    bit          sweep_done;

    // Table after reset: no groups, nothing armed
    for (int i = 0; i < TIMERS; i++) begin
      tm_expiry[i] = '0;
      tm_period[i] = '0;
      tm_group[i]  = '0;
    end

    // Directed part
    queue_req(ACT_SET_HANDLER, 4'd0, 31'd0, 32'd0, 8'h01, 1'b1, 32'd0);
    queue_req(ACT_SET_HANDLER, 4'd15, 31'd0, 32'd0, 8'hFF, 1'b1, 32'd0);
    queue_req(ACT_SET_HANDLER, 4'd5, 31'd0, 32'd0, 8'h80, 1'b0, 32'd0);
    queue_req(ACT_QUERY, 4'd0, 31'd0, 32'd0, 8'h00, 1'b0, 32'd0);
    // zero duration: due at once
    queue_req(ACT_ONESHOT_AFTR, 4'd0, 31'd0, 32'd0, 8'h00, 1'b0, 32'd100);
    // longest period, start near wrap
    queue_req(ACT_PERIODIC, 4'd15, 31'h7FFFFFFF, 32'd0, 8'h00, 1'b0, 32'hFFFFFFF0);
    queue_req(ACT_ONESHOT_AT, 4'd5, 31'd0, 32'hFFFFFFFF, 8'h00, 1'b0, 32'd0);
    queue_req(ACT_QUERY, 4'd15, 31'd0, 32'd0, 8'h00, 1'b0, 32'd0);
    queue_req(ACT_HANDLE, 4'd0, 31'd0, 32'd0, 8'h01, 1'b0, 32'd100);
    queue_req(ACT_HANDLE, 4'd0, 31'd0, 32'd0, 8'h00, 1'b0, 32'hFFFFFFFF);
    queue_req(ACT_HANDLE, 4'd0, 31'd0, 32'd0, 8'hFF, 1'b0, 32'h7FFFFFEF);
    queue_req(ACT_QUERY, 4'd15, 31'd0, 32'd0, 8'h00, 1'b0, 32'd0);
    queue_req(ACT_STOP, 4'd15, 31'd0, 32'd0, 8'h00, 1'b0, 32'd0);
    queue_req(ACT_QUERY, 4'd15, 31'd0, 32'd0, 8'h00, 1'b0, 32'd0);
    queue_req(ACT_SET_HANDLER, 4'd3, 31'd0, 32'd0, 8'h02, 1'b1, 32'd0);
    queue_req(ACT_PERIODIC, 4'd3, 31'd1, 32'd0, 8'h00, 1'b0, 32'd50);
    queue_req(ACT_STOP_GROUP, 4'd0, 31'd0, 32'd0, 8'h02, 1'b0, 32'd0);
    queue_req(ACT_QUERY, 4'd3, 31'd0, 32'd0, 8'h00, 1'b0, 32'd0);
    queue_req(ACT_ONESHOT_AFTR, 4'd3, 31'd10, 32'd0, 8'h00, 1'b0, 32'd50);
    queue_req(ACT_STOP_CLEAR, 4'd0, 31'd0, 32'd0, 8'h06, 1'b0, 32'd0);
    queue_req(ACT_HANDLE, 4'd0, 31'd0, 32'd0, 8'hFF, 1'b0, 32'd1000);
    // undefined action codes
    queue_req(4'(ACT_HANDLE + 1), 4'd7, 31'd5, 32'd5, 8'h55, 1'b1, 32'd5);
    queue_req(ACT_TOP_CODE, 4'hF, 31'h7FFFFFFF, 32'hFFFFFFFF, 8'hFF, 1'b1, 32'hFFFFFFFF);

    // Random part
    base       = req_queue.size();
    clock_ms   = $urandom;
    sweep_done = 1'b0;
    while (req_queue.size() < base + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (!sweep_done || pick < 4) begin
        // every timer due at once, all with handlers
        sweep_done = 1'b1;
        for (int i = 0; i < TIMERS; i++) begin
          queue_req(ACT_SET_HANDLER, 4'(i), 31'($urandom), $urandom,
                    8'(1 << $urandom_range(0, 7)), 1'b1, $urandom);
        end
        for (int i = 0; i < TIMERS; i++) begin
          act = 4'($urandom_range(1, 3));
          queue_req(act, 4'(i), 31'($urandom_range(0, 20)),
                    clock_ms + $urandom_range(0, 20), 8'($urandom), 1'($urandom), clock_ms);
        end
        clock_ms = clock_ms + 25;
        queue_req(ACT_HANDLE, 4'($urandom), 31'($urandom), $urandom, 8'hFF, 1'($urandom),
                  clock_ms);
      end else if (pick < 75) begin
        k = $urandom_range(1, 4);
        for (int j = 0; j < k; j++) begin
          id = 4'($urandom);
          if ($urandom_range(0, 1) == 0) begin
            m = ($urandom_range(0, 1) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom);
            queue_req(ACT_SET_HANDLER, id, 31'($urandom), $urandom, m,
                      1'($urandom_range(0, 3) != 0), $urandom);
          end
          act = 4'($urandom_range(1, 3));
          dur = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 60));
          queue_req(act, id, dur,
                    ($urandom_range(0, 9) == 0) ? $urandom : clock_ms + $urandom_range(0, 60),
                    8'($urandom), 1'($urandom), clock_ms);
        end
        clock_ms = clock_ms + $urandom_range(0, 40);
        if ($urandom_range(0, 49) == 0) begin
          clock_ms = clock_ms + $urandom;
        end
        case ($urandom_range(0, 5))
          0: queue_req(ACT_QUERY, 4'($urandom), 31'($urandom), $urandom, 8'($urandom),
                       1'($urandom), $urandom);
          1: queue_req(ACT_STOP, 4'($urandom), 31'($urandom), $urandom, 8'($urandom),
                       1'($urandom), $urandom);
          2: queue_req(($urandom_range(0, 1) == 0) ? ACT_STOP_GROUP : ACT_STOP_CLEAR,
                       4'($urandom), 31'($urandom), $urandom, 8'(1 << $urandom_range(0, 7)),
                       1'($urandom), $urandom);
          default: ;
        endcase
        queue_req(ACT_HANDLE, 4'($urandom), 31'($urandom), $urandom,
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF, 1'($urandom), clock_ms);
      end else begin
        // noise: any code, any operands
        queue_req(4'($urandom), 4'($urandom), 31'($urandom), $urandom, 8'($urandom),
                  1'($urandom), $urandom);
      end
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/gtt_pkg.sv
src/gtt_ram.sv
src/grouped_timer_table_core.sv
src/gtt_checker.sv
tb/sv/tb.sv
